// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the divider.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define IDV_ASSERT_RST(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("divider assertion failed");

// Clocked assertion that also holds through reset.
`define IDV_ASSERT(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("divider assertion failed");

`endif

// ----- hw/rtl/idv_pkg.sv -----
// Package for the 64-bit signed/unsigned divider: widths, operation codes
// and the per-stage payload struct. No dependencies.
`default_nettype none

package idv_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int PORT_WIDTH = 64;
  localparam int IN_TDATA_W = 2 * PORT_WIDTH;
  localparam int FUNC_W     = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_UQUO = 2'd0,
    FUNC_UREM = 2'd1,
    FUNC_SQUO = 2'd2,
    FUNC_SREM = 2'd3
  } func_t;

  // Payload handed from stage to stage. nq holds the dividend bits still to
  // be consumed in its upper part and the quotient bits found so far below.
  typedef struct packed {
    func_t                 func;
    logic                  a_neg;
    logic                  b_neg;
    logic                  zero;
    logic [DATA_WIDTH-1:0] rem;
    logic [DATA_WIDTH-1:0] nq;
    logic [DATA_WIDTH-1:0] den;
  } stage_t;

endpackage

`default_nettype wire

// ----- hw/rtl/idv_front.sv -----
// Input stage of the divider: takes operand magnitudes and flags zero divisor.
// Depends on idv_pkg.
`default_nettype none

module idv_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire idv_pkg::func_t                   in_func,
  input  wire logic [idv_pkg::IN_TDATA_W-1:0]   in_data,
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      idv_pkg::stage_t                  out_data
);

  localparam int W = idv_pkg::DATA_WIDTH;

  logic            valid_r;
  idv_pkg::stage_t data_r;
  idv_pkg::stage_t data_nxt;
  logic [W-1:0]    a;
  logic [W-1:0]    b;
  logic            is_signed;

  assign a = in_data[W-1:0];
  assign b = in_data[idv_pkg::PORT_WIDTH +: W];
  assign is_signed = (in_func == idv_pkg::FUNC_SQUO) || (in_func == idv_pkg::FUNC_SREM);

  always_comb begin
    data_nxt.func  = in_func;
    data_nxt.a_neg = is_signed & a[W-1];
    data_nxt.b_neg = is_signed & b[W-1];
    data_nxt.zero  = (b == '0);
    data_nxt.rem   = '0;
    data_nxt.nq    = data_nxt.a_neg ? (~a + 1'b1) : a;
    data_nxt.den   = data_nxt.b_neg ? (~b + 1'b1) : b;
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/idv_cell.sv -----
// One restoring-division step: shift in a dividend bit, trial subtract,
// keep or restore, record the quotient bit. Depends on idv_pkg.
`default_nettype none

module idv_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output      logic            in_ready,
  input  wire idv_pkg::stage_t in_data,
  output      logic            out_valid,
  input  wire logic            out_ready,
  output      idv_pkg::stage_t out_data
);

  localparam int W = idv_pkg::DATA_WIDTH;

  logic            valid_r;
  idv_pkg::stage_t data_r;
  idv_pkg::stage_t data_nxt;
  logic [W:0]      trial;
  logic [W+1:0]    diff;
  logic            take;

  // Partial remainder is one bit wider than the data to hold the carry.
  assign trial = {in_data.rem, in_data.nq[W-1]};
  assign diff  = {1'b0, trial} - {2'b00, in_data.den};
  assign take  = !diff[W+1];

  always_comb begin
    data_nxt     = in_data;
    data_nxt.rem = take ? diff[W-1:0] : trial[W-1:0];
    data_nxt.nq  = {in_data.nq[W-2:0], take};
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/idv_back.sv -----
// Output stage of the divider: sign fix, result select, output register.
// Depends on idv_pkg.
`default_nettype none

module idv_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire idv_pkg::stage_t                in_data,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic [idv_pkg::PORT_WIDTH-1:0] out_data
);

  localparam int W = idv_pkg::DATA_WIDTH;

  logic         valid_r;
  logic [W-1:0] ans_r;
  logic [W-1:0] ans_nxt;

  always_comb begin
    case (in_data.func)
      idv_pkg::FUNC_UQUO: ans_nxt = in_data.nq;
      idv_pkg::FUNC_UREM: ans_nxt = in_data.rem;
      idv_pkg::FUNC_SQUO: ans_nxt = (in_data.a_neg ^ in_data.b_neg) ?
                                    (~in_data.nq + 1'b1) : in_data.nq;
      idv_pkg::FUNC_SREM: ans_nxt = in_data.a_neg ? (~in_data.rem + 1'b1) : in_data.rem;
      default:            ans_nxt = in_data.nq;
    endcase
    if (in_data.zero) begin
      ans_nxt = '0;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = idv_pkg::PORT_WIDTH'(ans_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      ans_r <= ans_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/int64_divider_signed_unsigned.sv -----
// Pipeline from an accepted input beat to out_tvalid: one magnitude stage,
//   one restoring-step cell per quotient bit, one output stage.
// Throughput: one beat per cycle while out_tready is high; a stalled stage holds its beat.
// Reset: synchronous, active low rst_n; clears every stage's valid bit,
//   payload registers are not reset.
// Depends on idv_pkg, idv_front, idv_cell, idv_back.
`default_nettype none

module int64_divider_signed_unsigned (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input channel
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  input  wire logic [idv_pkg::IN_TDATA_W-1:0]    in_tdata,  // [63:0] dividend, [127:64] divisor
  input  wire logic [idv_pkg::FUNC_W-1:0]        in_tuser,  // [1:0] func
  // Result channel
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  output      logic [idv_pkg::PORT_WIDTH-1:0]    out_tdata  // [63:0] answer
);

  localparam int W = idv_pkg::DATA_WIDTH;

  // Stage k carries a beat that has completed k restoring steps.
  idv_pkg::stage_t stage_data [0:W];
  logic            stage_vld  [0:W];
  // stage_rdy[k] is the ready seen by the producer of stage k.
  logic            stage_rdy  [0:W];
  logic            back_rdy;

  // Operand magnitudes, sign flags and zero-divisor flag.
  idv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_func   (idv_pkg::func_t'(in_tuser)),
    .in_data   (in_tdata),
    .out_valid (stage_vld[0]),
    .out_ready (stage_rdy[0]),
    .out_data  (stage_data[0])
  );

  // Chain of restoring-step cells, most significant quotient bit first.
  // Ready ripples back through the chain so a bubble anywhere is filled.
  for (genvar k = 0; k < W; k++) begin : g_cell
    idv_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stage_vld[k]),
      .in_ready  (stage_rdy[k]),
      .in_data   (stage_data[k]),
      .out_valid (stage_vld[k+1]),
      .out_ready ((k == W - 1) ? back_rdy : stage_rdy[k+1]),
      .out_data  (stage_data[k+1])
    );
  end

  // Drive the top ready slot from the output stage so every element is driven and read.
  assign stage_rdy[W] = back_rdy;

  // Sign correction and quotient/remainder select; holds the result beat
  // while out_tready is low, which stalls the cells behind it.
  idv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (stage_vld[W] && stage_rdy[W]),
    .in_ready  (back_rdy),
    .in_data   (stage_data[W]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/idv_checker.sv -----
// Port-level checker for the divider, bound to the top level.
// Depends on idv_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module idv_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [idv_pkg::PORT_WIDTH-1:0] out_tdata
);

  // A stalled result beat holds.
  `IDV_ASSERT_RST(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  // With the output free to drain, the input side is never stalled.
  `IDV_ASSERT_RST(a_in_free, clk, rst_n, (!out_tvalid || out_tready) |-> in_tready)
  // Reset empties the pipeline.
  `IDV_ASSERT(a_rst_empty, clk, !rst_n |=> !out_tvalid)

endmodule

bind int64_divider_signed_unsigned idv_checker u_idv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking bench for int64_divider_signed_unsigned: directed corner cases,
// a full-rate burst and random divisions with idle gaps and output stalls.
// Depends on idv_pkg and the divider RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int DATA_WIDTH = idv_pkg::DATA_WIDTH;
  localparam int PORT_WIDTH = idv_pkg::PORT_WIDTH;
  localparam int IN_TDATA_W = idv_pkg::IN_TDATA_W;
  localparam int FUNC_W     = idv_pkg::FUNC_W;

  typedef idv_pkg::func_t func_t;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any beat moving
  localparam int DRAIN_CYCLES   = DATA_WIDTH + 20;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int BURST_ITEMS    = 100;

  localparam logic [DATA_WIDTH-1:0] ALL_ONES  = '1;
  localparam logic [DATA_WIDTH-1:0] MOST_NEG  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] MOST_POS  = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [63:0] dividend, [127:64] divisor
  logic [FUNC_W-1:0]      in_tuser;   // [1:0] func
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [PORT_WIDTH-1:0]  out_tdata;  // [63:0] answer

  // Answers predicted for accepted beats, oldest first.
  logic [PORT_WIDTH-1:0]  answer_q[$];
  int                     error_count = 0;
  int                     quiet_cycles = 0;
  int                     stall_left = 0;
  bit                     idle_en = 1'b1;  // clear to run both sides at full rate

  always #5 clk = ~clk;

  int64_divider_signed_unsigned DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = int'($urandom_range(0, 99));
    if (roll < 55) return 0;
    if (roll < 85) return int'($urandom_range(1, 3));
    if (roll < 97) return int'($urandom_range(4, 15));
    return int'($urandom_range(30, 150));
  endfunction

  // Restoring division on magnitudes with a remainder one bit wider than the
  // data, then sign fix-up for the signed operations. Zero divisor gives zero.
  function automatic logic [PORT_WIDTH-1:0] predict_answer(func_t op,
                                                          logic [DATA_WIDTH-1:0] num,
                                                          logic [DATA_WIDTH-1:0] den);
    logic                  is_signed;
    logic                  num_neg;
    logic                  den_neg;
    logic [DATA_WIDTH-1:0] num_mag;
    logic [DATA_WIDTH-1:0] den_mag;
    logic [DATA_WIDTH-1:0] quo;
    logic [DATA_WIDTH-1:0] rem;
    logic [DATA_WIDTH:0]   partial;
    int                    bit_idx;
    if (den == '0) return '0;
    is_signed = (op == idv_pkg::FUNC_SQUO) || (op == idv_pkg::FUNC_SREM);
    num_neg   = is_signed && num[DATA_WIDTH-1];
    den_neg   = is_signed && den[DATA_WIDTH-1];
    num_mag   = num_neg ? -num : num;
    den_mag   = den_neg ? -den : den;
    partial   = '0;
    quo       = '0;
    for (bit_idx = DATA_WIDTH - 1; bit_idx >= 0; bit_idx--) begin
      partial = {partial[DATA_WIDTH-1:0], num_mag[bit_idx]};
      if (partial >= {1'b0, den_mag}) begin
        partial      = partial - {1'b0, den_mag};
        quo[bit_idx] = 1'b1;
      end
    end
    rem = partial[DATA_WIDTH-1:0];
    case (op)
      idv_pkg::FUNC_UQUO: return quo;
      idv_pkg::FUNC_UREM: return rem;
      idv_pkg::FUNC_SQUO: return (num_neg != den_neg) ? -quo : quo;
      default:            return num_neg ? -rem : rem;
    endcase
  endfunction

  // Operand drawn from one of several shapes so that signs, small values,
  // wide magnitudes and the edge patterns all show up often.
  function automatic logic [DATA_WIDTH-1:0] rand_operand();
    logic [DATA_WIDTH-1:0] wide;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0, 7: return wide;
      1:    return DATA_WIDTH'($urandom_range(0, 15));
      2:    return -DATA_WIDTH'($urandom_range(1, 15));
      3:    return wide | MOST_NEG;
      4: begin
        case ($urandom_range(0, 5))
          0:       return '0;
          1:       return DATA_WIDTH'(1);
          2:       return ALL_ONES;
          3:       return MOST_NEG;
          4:       return MOST_POS;
          default: return DATA_WIDTH'(2);
        endcase
      end
      5:    return wide >> $urandom_range(0, DATA_WIDTH - 1);
      default: return -(wide >> $urandom_range(0, DATA_WIDTH - 1));
    endcase
  endfunction

  // Present one division and hold it until the block takes it. Called right
  // after a rising edge; leaves in_tvalid high so back-to-back beats need no
  // second assignment in the same step.
  task automatic send_division(func_t op, logic [DATA_WIDTH-1:0] num,
                               logic [DATA_WIDTH-1:0] den);
    int gap;
    gap = idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {den, num};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    logic [DATA_WIDTH-1:0] nums[6];
    logic [DATA_WIDTH-1:0] dens[6];
    int                    pair;
    int                    op;
    // zero divisor, most negative by minus one, divisor with its top bit set,
    // negative dividend, negative divisor, zero dividend
    nums = '{64'h0123_4567_89AB_CDEF, MOST_NEG, ALL_ONES,
             -64'd7, 64'd7, 64'd0};
    dens = '{64'd0, ALL_ONES, 64'h8000_0000_0000_0001,
             64'd2, -64'd2, ALL_ONES};
    for (pair = 0; pair < 6; pair++) begin
      for (op = 0; op < 4; op++) begin
        send_division(func_t'(op), nums[pair], dens[pair]);
      end
    end
  endtask

  // Both sides at full rate: one beat per cycle through the whole pipeline.
  task automatic test_full_rate();
    int n;
    idle_en = 1'b0;
    for (n = 0; n < BURST_ITEMS; n++) begin
      send_division(func_t'($urandom_range(0, 3)), rand_operand(), rand_operand());
    end
    idle_en = 1'b1;
  endtask

  task automatic test_random_divisions();
    int n;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // drop idling for a stretch now and then
      if (n % 200 == 0) idle_en = ($urandom_range(0, 3) != 0);
      send_division(func_t'($urandom_range(0, 3)), rand_operand(), rand_operand());
    end
    idle_en = 1'b1;
  endtask

  // Result side back-pressure, same gap shape as the input side.
  always @(posedge clk) begin : rx_stall
    int gap;
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      gap = idle_en ? pick_gap() : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        stall_left <= gap - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Predict on every accepted input beat; check every accepted result beat
  // against the oldest prediction.
  always @(posedge clk) begin : scoreboard
    logic [PORT_WIDTH-1:0] want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (answer_q.size() == 0) begin
          $error("answer: expected none, actual %h", out_tdata);
          error_count++;
        end else begin
          want = answer_q.pop_front();
          if (out_tdata !== want) begin
            $error("answer: expected %h, actual %h", want, out_tdata);
            error_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        answer_q.push_back(predict_answer(func_t'(in_tuser),
                                          in_tdata[DATA_WIDTH-1:0],
                                          in_tdata[PORT_WIDTH +: DATA_WIDTH]));
      end
    end
  end

  // Advance a counter while no beat moves on either side; end the run on hang.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= idv_pkg::FUNC_UQUO;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_full_rate();
    test_random_divisions();
    in_tvalid <= 1'b0;

    // Hold until every prediction is matched, then let the pipeline drain.
    while (answer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && answer_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/idv_pkg.sv
hw/rtl/idv_front.sv
hw/rtl/idv_cell.sv
hw/rtl/idv_back.sv
hw/rtl/int64_divider_signed_unsigned.sv
hw/rtl/idv_checker.sv
tb/testbench.sv
